### sv/tgc_pkg.sv
// Package for the temperature gauge classifier: types, register codes and constants.
`timescale 1ns / 1ps
`default_nettype none

package tgc_pkg;

    // Field widths
    localparam int TEMP_W    = 8;
    localparam int SCALED_W  = 15;
    localparam int BAR_W     = 3;
    localparam int CFG_IDX_W = 4;
    localparam int NUM_BARS  = 6;

    // Register index codes
    localparam logic [CFG_IDX_W-1:0] REG_BAR_FIRST  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAR_SECOND = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAR_THIRD  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAR_FOURTH = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAR_FIFTH  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BAR_SIXTH  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_ON    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_OFF   = 4'd7;

    // Register reset values
    localparam logic [TEMP_W-1:0] RST_BAR_FIRST  = 8'd20;
    localparam logic [TEMP_W-1:0] RST_BAR_SECOND = 8'd80;
    localparam logic [TEMP_W-1:0] RST_BAR_THIRD  = 8'd100;
    localparam logic [TEMP_W-1:0] RST_BAR_FOURTH = 8'd110;
    localparam logic [TEMP_W-1:0] RST_BAR_FIFTH  = 8'd120;
    localparam logic [TEMP_W-1:0] RST_BAR_SIXTH  = 8'd150;
    localparam logic [TEMP_W-1:0] RST_WARN_ON    = 8'd110;
    localparam logic [TEMP_W-1:0] RST_WARN_OFF   = 8'd100;

    // Dead-band and scaling constants
    localparam logic [TEMP_W-1:0] FAST_RISE_LEVEL = 8'd150;
    localparam logic [TEMP_W-1:0] WIDE_BAND_LEVEL = 8'd20;
    localparam logic [9:0]        KELVIN_OFFSET   = 10'd273;
    localparam int                SCALE_SHIFT     = 5;
    localparam logic [BAR_W-1:0]  BAR_MAX         = 3'd6;

    // Threshold set seen by the classifier
    typedef struct packed {
        logic [NUM_BARS-1:0][TEMP_W-1:0] bar_on;
        logic [TEMP_W-1:0]               warn_on;
        logic [TEMP_W-1:0]               warn_off;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic [TEMP_W-1:0]   held_temperature;
        logic [SCALED_W-1:0] scaled_value;
        logic                warning;
        logic [BAR_W-1:0]    bar_level;
    } t_result;

endpackage

`default_nettype wire

### sv/tgc_cfg.sv
// Configuration register file for the temperature gauge classifier.
`timescale 1ns / 1ps
`default_nettype none

module tgc_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [tgc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tgc_pkg::TEMP_W-1:0]    i_cfg_data,
    output tgc_pkg::t_cfg                      o_cfg
);
    import tgc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Write decode; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BAR_FIRST:  n_cfg.bar_on[0] = i_cfg_data;
                REG_BAR_SECOND: n_cfg.bar_on[1] = i_cfg_data;
                REG_BAR_THIRD:  n_cfg.bar_on[2] = i_cfg_data;
                REG_BAR_FOURTH: n_cfg.bar_on[3] = i_cfg_data;
                REG_BAR_FIFTH:  n_cfg.bar_on[4] = i_cfg_data;
                REG_BAR_SIXTH:  n_cfg.bar_on[5] = i_cfg_data;
                REG_WARN_ON:    n_cfg.warn_on   = i_cfg_data;
                REG_WARN_OFF:   n_cfg.warn_off  = i_cfg_data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    // Register storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bar_on[0] <= RST_BAR_FIRST;
            r_cfg.bar_on[1] <= RST_BAR_SECOND;
            r_cfg.bar_on[2] <= RST_BAR_THIRD;
            r_cfg.bar_on[3] <= RST_BAR_FOURTH;
            r_cfg.bar_on[4] <= RST_BAR_FIFTH;
            r_cfg.bar_on[5] <= RST_BAR_SIXTH;
            r_cfg.warn_on   <= RST_WARN_ON;
            r_cfg.warn_off  <= RST_WARN_OFF;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### sv/tgc_core.sv
// Dead-band, warning and bar hysteresis state with the per-word result logic.
`timescale 1ns / 1ps
`default_nettype none

module tgc_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [tgc_pkg::TEMP_W-1:0] i_temperature,
    input  wire logic                       i_open_circuit,
    input  wire tgc_pkg::t_cfg              i_cfg,
    output tgc_pkg::t_result                o_result
);
    import tgc_pkg::*;

    logic [TEMP_W-1:0] r_last_held;
    logic              r_warn;
    logic [BAR_W-1:0]  r_bar;

    logic [TEMP_W-1:0] n_last_held;
    logic              n_warn;
    logic [BAR_W-1:0]  n_bar;

    logic [1:0]        margin;
    logic [TEMP_W-1:0] diff_up;
    logic [TEMP_W-1:0] diff_dn;
    logic [BAR_W-1:0]  bar_next;
    logic              bar_hit;
    logic [9:0]        kelvin;

    // Dead-band hold
    always_comb begin
        margin      = (i_temperature > WIDE_BAND_LEVEL) ? 2'd1 : 2'd2;
        diff_up     = i_temperature - r_last_held;
        diff_dn     = r_last_held - i_temperature;
        n_last_held = r_last_held;
        if (i_temperature > r_last_held) begin
            if (diff_up > {6'd0, margin} || i_temperature >= FAST_RISE_LEVEL) begin
                n_last_held = i_temperature;
            end
        end else if (i_temperature < r_last_held) begin
            if (diff_dn > {6'd0, margin} || i_temperature == '0) begin
                n_last_held = i_temperature;
            end
        end
    end

    // Bar level: rising tests first, then falling, first hit wins
    always_comb begin
        bar_next = r_bar;
        bar_hit  = 1'b0;
        if (r_bar == 3'd1 && n_last_held < i_cfg.bar_on[0]) begin
            bar_next = '0;
            bar_hit  = 1'b1;
        end
        for (int k = 1; k < NUM_BARS; k++) begin
            if (!bar_hit && r_bar <= BAR_W'(k) && n_last_held >= i_cfg.bar_on[k-1]
                && n_last_held < i_cfg.bar_on[k]) begin
                bar_next = BAR_W'(k);
                bar_hit  = 1'b1;
            end
        end
        if (!bar_hit && r_bar <= BAR_MAX && n_last_held >= i_cfg.bar_on[NUM_BARS-1]) begin
            bar_next = BAR_MAX;
            bar_hit  = 1'b1;
        end
        if (!bar_hit && r_bar != '0 && n_last_held <= i_cfg.bar_on[0]) begin
            bar_next = '0;
            bar_hit  = 1'b1;
        end
        for (int k = 1; k < NUM_BARS; k++) begin
            if (!bar_hit && r_bar > BAR_W'(k) && n_last_held < i_cfg.bar_on[k]) begin
                bar_next = BAR_W'(k);
                bar_hit  = 1'b1;
            end
        end
    end

    // Warning and bar freeze on open circuit
    always_comb begin
        n_warn = r_warn;
        n_bar  = r_bar;
        if (!i_open_circuit) begin
            if (n_last_held >= i_cfg.warn_on) begin
                n_warn = 1'b1;
            end else if (n_last_held <= i_cfg.warn_off) begin
                n_warn = 1'b0;
            end
            n_bar = bar_next;
        end
    end

    // State update on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_held <= '0;
            r_warn      <= 1'b0;
            r_bar       <= '0;
        end else if (i_accept) begin
            r_last_held <= n_last_held;
            r_warn      <= n_warn;
            r_bar       <= n_bar;
        end
    end

    // Result word
    assign kelvin                    = {2'd0, n_last_held} + KELVIN_OFFSET;
    assign o_result.held_temperature = n_last_held;
    assign o_result.scaled_value     = {kelvin, {SCALE_SHIFT{1'b0}}};
    assign o_result.warning          = n_warn;
    assign o_result.bar_level        = n_bar;

`ifndef SYNTH
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_open_circuit) |=> (r_warn == $past(r_warn) && r_bar == $past(r_bar)))
        else $error("warning or bar moved during open circuit");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> ($stable(r_last_held) && $stable(r_warn) && $stable(r_bar)))
        else $error("state changed without an accepted word");

    a_bar_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bar <= BAR_MAX)
        else $error("bar level out of range");
`endif

endmodule

`default_nettype wire

### sv/temperature_gauge_classifier.sv
// Top level of the temperature gauge classifier.
`timescale 1ns / 1ps
`default_nettype none

// Temperature gauge classifier. Each input word (temperature in degrees C plus an
// open-circuit flag) passes a dead-band, then sets a hysteretic warning flag, a
// 0..6 bar level and the value (held + 273) * 32. The block takes one word per
// clock unless the output stalls: the dead-band, threshold compares and scaling
// are one combinational pass from the state registers into the output register,
// so a result is ready in the cycle after its word is accepted. The output
// register frees as its word is taken, so input is accepted whenever the output
// is empty or being read. Configuration writes should only be made while idle.
module temperature_gauge_classifier (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [tgc_pkg::TEMP_W-1:0]    i_temperature,
    input  wire logic                          i_open_circuit,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [tgc_pkg::TEMP_W-1:0]         o_held_temperature,
    output logic [tgc_pkg::SCALED_W-1:0]       o_scaled_value,
    output logic                               o_warning,
    output logic [tgc_pkg::BAR_W-1:0]          o_bar_level,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [tgc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tgc_pkg::TEMP_W-1:0]    i_cfg_data
);
    import tgc_pkg::*;

    t_cfg    cfg;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    in_accept;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_out_valid || i_ready;
    assign in_accept   = i_valid && o_ready;

    tgc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tgc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_temperature  (i_temperature),
        .i_open_circuit (i_open_circuit),
        .i_cfg          (cfg),
        .o_result       (result)
    );

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_held_temperature = r_out.held_temperature;
    assign o_scaled_value     = r_out.scaled_value;
    assign o_warning          = r_out.warning;
    assign o_bar_level        = r_out.bar_level;

endmodule

`default_nettype wire

### tb/tb_temperature_gauge_classifier.sv
// Self-checking testbench for the temperature gauge classifier: directed and random samples.
`timescale 1ns / 1ps

module tb_temperature_gauge_classifier;
    import tgc_pkg::*;

    localparam int NUM_REGS = 8;
    // first index past the last register, writes from here up are ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 4'd15;

    typedef logic [TEMP_W-1:0] t_thr_set [NUM_REGS];

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [TEMP_W-1:0]    i_temperature;
    logic                 i_open_circuit;
    logic                 o_valid;
    logic                 i_ready;
    logic [TEMP_W-1:0]    o_held_temperature;
    logic [SCALED_W-1:0]  o_scaled_value;
    logic                 o_warning;
    logic [BAR_W-1:0]     o_bar_level;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [TEMP_W-1:0]    i_cfg_data;

    temperature_gauge_classifier DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_temperature      (i_temperature),
        .i_open_circuit     (i_open_circuit),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_held_temperature (o_held_temperature),
        .o_scaled_value     (o_scaled_value),
        .o_warning          (o_warning),
        .o_bar_level        (o_bar_level),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // Predictor state: thresholds, held value, warning flag, bar count
    logic [TEMP_W-1:0] gauge_cfg [NUM_REGS];
    int                held_q;
    logic              warn_q;
    int                bar_q;

    t_result expected_readings [$];
    int      mismatch_count   = 0;
    int      results_checked  = 0;
    int      open_samples     = 0;
    int      settings_applied = 0;
    int      last_sent        = 0;
    bit      idling_on        = 1'b0;

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Bar level after hysteresis, rising tests first, then falling
    function automatic int next_bar_level(input int lvl, input int h);
        int k;
        int nxt;
        nxt = -1;
        if (lvl == 1 && h < gauge_cfg[REG_BAR_FIRST])
            nxt = 0;
        for (k = 1; k <= 5 && nxt < 0; k++) begin
            if (lvl <= k && h >= gauge_cfg[REG_BAR_FIRST + k - 1] && h < gauge_cfg[REG_BAR_FIRST + k])
                nxt = k;
        end
        if (nxt < 0 && lvl <= 6 && h >= gauge_cfg[REG_BAR_SIXTH])
            nxt = 6;
        if (nxt < 0 && lvl > 0 && h <= gauge_cfg[REG_BAR_FIRST])
            nxt = 0;
        // off threshold is on(k+1) - 1, written as a strict compare
        for (k = 1; k <= 5 && nxt < 0; k++) begin
            if (lvl > k && h < gauge_cfg[REG_BAR_FIRST + k])
                nxt = k;
        end
        if (nxt < 0)
            nxt = lvl;
        return nxt;
    endfunction

    // Expected reading for one accepted sample; advances predictor state
    function automatic t_result predict_reading(input logic [TEMP_W-1:0] temp,
                                                 input logic sensor_open);
        t_result r;
        int      t;
        int      margin;
        t = temp;
        margin = (t > WIDE_BAND_LEVEL) ? 1 : 2;
        // dead-band
        if (t > held_q) begin
            if (t - held_q > margin || t >= FAST_RISE_LEVEL)
                held_q = t;
        end else if (t < held_q) begin
            if (held_q - t > margin || t == 0)
                held_q = t;
        end
        // warning and bar freeze while the sensor is open
        if (!sensor_open) begin
            if (held_q >= gauge_cfg[REG_WARN_ON])
                warn_q = 1'b1;
            else if (held_q <= gauge_cfg[REG_WARN_OFF])
                warn_q = 1'b0;
            bar_q = next_bar_level(bar_q, held_q);
        end
        r.held_temperature = held_q[TEMP_W-1:0];
        r.scaled_value     = SCALED_W'((held_q + KELVIN_OFFSET) << SCALE_SHIFT);
        r.warning          = warn_q;
        r.bar_level        = bar_q[BAR_W-1:0];
        return r;
    endfunction

    // Send one sample word, with an optional idle burst before it
    task automatic send_sample(input int temp, input logic sensor_open);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_temperature  <= temp[TEMP_W-1:0];
        i_open_circuit <= sensor_open;
        do @(posedge i_clk); while (!o_ready);
        expected_readings.push_back(predict_reading(temp[TEMP_W-1:0], sensor_open));
        if (sensor_open)
            open_samples++;
    endtask

    // Stop sending and wait for every expected reading, then let the pipe settle
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write all registers back to back, then a stray write to an unused index
    task automatic program_thresholds(input t_thr_set vals);
        int r;
        wait_drained();
        for (r = 0; r < NUM_REGS; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REG_BAR_FIRST + CFG_IDX_W'(r);
            i_cfg_data  <= vals[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            gauge_cfg[r] = vals[r];
        end
        i_cfg_index <= CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST));
        i_cfg_data  <= TEMP_W'($urandom);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Sample source: mostly small walks and values near thresholds
    function automatic int pick_temperature();
        int t;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 3)
            t = last_sent + int'($urandom_range(0, 6)) - 3;
        else if (sel <= 5)
            t = int'(gauge_cfg[$urandom_range(0, NUM_REGS - 1)]) + int'($urandom_range(0, 6)) - 3;
        else if (sel <= 7)
            t = $urandom_range(0, 255);
        else if (sel == 8)
            t = 0;
        else
            t = $urandom_range(FAST_RISE_LEVEL, 255);
        if (t < 0)
            t = 0;
        if (t > 255)
            t = 255;
        last_sent = t;
        return t;
    endfunction

    task automatic run_random_samples(input int count, input bit allow_idle);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 40 == 0)
                idling_on = allow_idle && ($urandom_range(0, 3) != 0);
            send_sample(pick_temperature(), $urandom_range(0, 7) == 0);
        end
    endtask

    // Dead-band edges, bar levels 0 to 4 and 6, warning hysteresis, open sensor, fast rise
    task automatic test_directed_walk();
        int temps [24] = '{0, 2, 3, 1, 0, 22, 23, 24, 80, 100, 110, 109,
                           105, 149, 150, 151, 255, 254, 255, 0, 0, 20, 19, 17};
        bit opens [24] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                           0, 1, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0};
        int n;
        idling_on = 1'b0;
        for (n = 0; n < 24; n++)
            send_sample(temps[n], opens[n]);
    endtask

    task automatic test_default_thresholds();
        run_random_samples(180, 1'b1);
    endtask

    // Random thresholds in non-decreasing order, warn off below warn on
    task automatic test_ordered_thresholds();
        t_thr_set vals;
        int       pass;
        int       k;
        int       step;
        for (pass = 0; pass < 3; pass++) begin
            vals[REG_BAR_FIRST] = TEMP_W'($urandom_range(0, 60));
            for (k = 1; k < NUM_BARS; k++) begin
                step = $urandom_range(0, 45);
                vals[REG_BAR_FIRST + k] = (int'(vals[REG_BAR_FIRST + k - 1]) + step > 255) ?
                    8'd255 : TEMP_W'(int'(vals[REG_BAR_FIRST + k - 1]) + step);
            end
            vals[REG_WARN_ON]  = TEMP_W'($urandom_range(1, 255));
            vals[REG_WARN_OFF] = TEMP_W'($urandom_range(0, vals[REG_WARN_ON] - 1));
            program_thresholds(vals);
            run_random_samples(140, 1'b1);
        end
    endtask

    // Any order at all, including overlapping warning levels
    task automatic test_unordered_thresholds();
        t_thr_set vals;
        int       k;
        for (k = 0; k < NUM_REGS; k++)
            vals[k] = TEMP_W'($urandom);
        program_thresholds(vals);
        run_random_samples(150, 1'b1);
    endtask

    // All-zero thresholds (off threshold of zero never matches), then all-full
    task automatic test_extreme_thresholds();
        t_thr_set vals;
        int       k;
        for (k = 0; k < NUM_REGS; k++)
            vals[k] = '0;
        program_thresholds(vals);
        run_random_samples(50, 1'b1);
        for (k = 0; k < NUM_REGS; k++)
            vals[k] = '1;
        program_thresholds(vals);
        run_random_samples(50, 1'b1);
    endtask

    // Back to reset thresholds, full rate on both sides
    task automatic test_full_rate();
        t_thr_set vals = '{RST_BAR_FIRST, RST_BAR_SECOND, RST_BAR_THIRD, RST_BAR_FOURTH,
                           RST_BAR_FIFTH, RST_BAR_SIXTH, RST_WARN_ON, RST_WARN_OFF};
        program_thresholds(vals);
        run_random_samples(120, 1'b0);
        idling_on = 1'b0;
    endtask

    // Receiver: random stall bursts while idling is on
    initial begin
        int stall;
        stall = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 11) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Result checker: each word against the oldest expected reading
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch($sformatf("unexpected word held=%0d", o_held_temperature));
            end else begin
                want = expected_readings.pop_front();
                results_checked++;
                if (o_held_temperature !== want.held_temperature)
                    report_mismatch($sformatf("held_temperature got %0d want %0d",
                                              o_held_temperature, want.held_temperature));
                if (o_scaled_value !== want.scaled_value)
                    report_mismatch($sformatf("scaled_value got %0d want %0d",
                                              o_scaled_value, want.scaled_value));
                if (o_warning !== want.warning)
                    report_mismatch($sformatf("warning got %0b want %0b",
                                              o_warning, want.warning));
                if (o_bar_level !== want.bar_level)
                    report_mismatch($sformatf("bar_level got %0d want %0d",
                                              o_bar_level, want.bar_level));
            end
        end
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("Run limit reached with %0d readings outstanding", expected_readings.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_temperature  <= '0;
        i_open_circuit <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        gauge_cfg = '{RST_BAR_FIRST, RST_BAR_SECOND, RST_BAR_THIRD, RST_BAR_FOURTH,
                      RST_BAR_FIFTH, RST_BAR_SIXTH, RST_WARN_ON, RST_WARN_OFF};
        held_q = 0;
        warn_q = 1'b0;
        bar_q  = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_walk();
        test_default_thresholds();
        test_ordered_thresholds();
        test_unordered_thresholds();
        test_extreme_thresholds();
        test_full_rate();

        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("Checked %0d readings across %0d threshold settings plus reset values,",
                 results_checked, settings_applied);
        $display("%0d of them taken with the sensor open; %0d mismatches", open_samples,
                 mismatch_count);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
